/* rtl/vibration_magnitude_hold_unit_macros.svh */
// ----------------------------------------------------------------------------
// Vibration magnitude hold unit assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef VIBRATION_MAGNITUDE_HOLD_UNIT_MACROS_SVH
`define VIBRATION_MAGNITUDE_HOLD_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VMH_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VMH_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/vmh_pkg.sv */
// ----------------------------------------------------------------------------
// Vibration magnitude hold package
// Widths, limits and the status bundle shared by the top level and its core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vmh_pkg;

    localparam int VMH_AXIS_W  = 16;
    localparam int VMH_ROOT_W  = 16;
    localparam int VMH_MAG_W   = 15;
    localparam int VMH_FRAME_W = 32;

    localparam logic [VMH_MAG_W-1:0] VMH_MAG_MAX = 15'h7FFF;

    typedef logic signed [VMH_AXIS_W-1:0] vmh_axis_t;

    // Status that the magnitude core reports to the frame controller.
    typedef struct packed {
        logic busy;
        logic done;
    } vmh_core_stat_t;

endpackage

`default_nettype wire

/* rtl/vibration_magnitude_hold_unit.sv */
// A frame with a good read is accepted and run through the serial core (8 squaring
// steps, then 16 square root steps); its magnitude is loaded into the result register
// once the core is done and the output is free. No new frame is taken until then.
// A frame with a failed read skips the core and goes straight to the result register.
// A waiting result does not block the next frame from being taken.
// Reset (aresetn low at a clock edge) zeroes the held axes, magnitude and frame count.
// ----------------------------------------------------------------------------
// Vibration magnitude hold unit
// Holds the last good accelerometer sample and its vector magnitude and tags
// every frame with a wrapping frame number.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "vibration_magnitude_hold_unit_macros.svh"

module vibration_magnitude_hold_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // accel_x [15:0], accel_y [31:16], accel_z [47:32]
    input  wire logic [0:0]  s_tuser,   // read_ok [0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // held_x [15:0], held_y [31:16], held_z [47:32],
                                        // vibration_mg [62:48], frame_number [94:63], zero [95]
    output logic [0:0]       m_tuser    // sample_valid [0]
);
    import vmh_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    vmh_axis_t              held_x_reg, held_x_next;
    vmh_axis_t              held_y_reg, held_y_next;
    vmh_axis_t              held_z_reg, held_z_next;
    logic [VMH_MAG_W-1:0]   mag_reg, mag_next;
    logic                   valid_flag_reg, valid_flag_next;
    logic [VMH_FRAME_W-1:0] frame_counter_reg, frame_counter_next;

    vmh_axis_t              in_x_reg;
    vmh_axis_t              in_y_reg;
    vmh_axis_t              in_z_reg;
    logic                   ok_reg;

    vmh_core_stat_t         core_stat;
    logic [VMH_ROOT_W-1:0]  core_root;
    logic [VMH_MAG_W-1:0]   mag_sat;
    logic                   in_accept;
    logic                   load_en;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign load_en   = (state_reg == ST_LOAD) && (!m_tvalid_reg || m_tready);
    assign mag_sat   = core_root[VMH_ROOT_W-1] ? VMH_MAG_MAX : core_root[VMH_MAG_W-1:0];

    vmh_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (in_accept && s_tuser[0]),
        .axis_x  (s_tdata[15:0]),
        .axis_y  (s_tdata[31:16]),
        .axis_z  (s_tdata[47:32]),
        .stat    (core_stat),
        .root    (core_root)
    );

    always_comb begin
        state_next         = state_reg;
        m_tvalid_next      = m_tvalid_reg && !m_tready;
        held_x_next        = held_x_reg;
        held_y_next        = held_y_reg;
        held_z_next        = held_z_reg;
        mag_next           = mag_reg;
        valid_flag_next    = valid_flag_reg;
        frame_counter_next = frame_counter_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = s_tuser[0] ? ST_BUSY : ST_LOAD;
                end
            end
            ST_BUSY: begin
                if (core_stat.done) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (load_en) begin
                    state_next         = ST_IDLE;
                    m_tvalid_next      = 1'b1;
                    valid_flag_next    = ok_reg;
                    frame_counter_next = frame_counter_reg + 32'd1;
                    if (ok_reg) begin
                        held_x_next = in_x_reg;
                        held_y_next = in_y_reg;
                        held_z_next = in_z_reg;
                        mag_next    = mag_sat;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The result register doubles as the held state of the block.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            m_tvalid_reg      <= 1'b0;
            held_x_reg        <= '0;
            held_y_reg        <= '0;
            held_z_reg        <= '0;
            mag_reg           <= '0;
            valid_flag_reg    <= 1'b0;
            frame_counter_reg <= '0;
        end else begin
            state_reg         <= state_next;
            m_tvalid_reg      <= m_tvalid_next;
            held_x_reg        <= held_x_next;
            held_y_reg        <= held_y_next;
            held_z_reg        <= held_z_next;
            mag_reg           <= mag_next;
            valid_flag_reg    <= valid_flag_next;
            frame_counter_reg <= frame_counter_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_x_reg <= s_tdata[15:0];
            in_y_reg <= s_tdata[31:16];
            in_z_reg <= s_tdata[47:32];
            ok_reg   <= s_tuser[0];
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {1'b0, frame_counter_reg, mag_reg, held_z_reg, held_y_reg, held_x_reg};
    assign m_tuser[0] = valid_flag_reg;

    `VMH_ASSERT_NOW(a_core_runs, aclk, aresetn, state_reg == ST_BUSY, core_stat.busy || core_stat.done, "core idle while a magnitude is pending")
    `VMH_ASSERT_NEXT(a_fail_skips_core, aclk, aresetn, in_accept && !s_tuser[0], state_reg == ST_LOAD && !core_stat.busy, "failed read did not go straight to the result")
    `VMH_ASSERT_NEXT(a_frame_step, aclk, aresetn, load_en, frame_counter_reg == $past(frame_counter_reg) + 32'd1, "frame number did not advance by one")
    `VMH_ASSERT_NEXT(a_fail_holds, aclk, aresetn, load_en && !ok_reg, $stable(mag_reg) && $stable(held_x_reg) && !m_tuser[0], "held sample changed on a failed read")

endmodule

`default_nettype wire

/* rtl/vmh_core.sv */
// ----------------------------------------------------------------------------
// Vibration magnitude core
// Serial sum of squares (two multiplier bits per cycle) followed by a
// restoring digit-by-digit square root (one root bit per cycle).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vmh_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire vmh_pkg::vmh_axis_t             axis_x,
    input  wire vmh_pkg::vmh_axis_t             axis_y,
    input  wire vmh_pkg::vmh_axis_t             axis_z,
    output vmh_pkg::vmh_core_stat_t             stat,
    output logic [vmh_pkg::VMH_ROOT_W-1:0]      root
);
    import vmh_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SQR  = 2'd1;
    localparam logic [1:0] PH_ROOT = 2'd2;

    localparam logic [2:0] SQR_LAST  = 3'd7;
    localparam logic [3:0] ROOT_LAST = 4'd15;

    function automatic logic [15:0] abs16(input logic [15:0] v);
        abs16 = v[15] ? (16'd0 - v) : v;
    endfunction

    // Magnitude times one two-bit multiplier digit.
    function automatic logic [17:0] digit_prod(input logic [15:0] m, input logic [1:0] d);
        digit_prod = ({2'b00, m} & {18{d[0]}}) + ({1'b0, m, 1'b0} & {18{d[1]}});
    endfunction

    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [15:0] mul_x_reg, mul_x_next;
    logic [15:0] mul_y_reg, mul_y_next;
    logic [15:0] mul_z_reg, mul_z_next;
    logic [15:0] dig_x_reg, dig_x_next;
    logic [15:0] dig_y_reg, dig_y_next;
    logic [15:0] dig_z_reg, dig_z_next;
    logic [16:0] hi_reg, hi_next;
    logic [15:0] lo_reg, lo_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] root_reg, root_next;

    logic [18:0] addend;
    logic [18:0] part_sum;
    logic [31:0] sum_w;
    logic [18:0] rem_try;
    logic [18:0] trial;
    logic [18:0] diff;
    logic        take;

    assign addend = {1'b0, digit_prod(mul_x_reg, dig_x_reg[1:0])}
                  + {1'b0, digit_prod(mul_y_reg, dig_y_reg[1:0])}
                  + {1'b0, digit_prod(mul_z_reg, dig_z_reg[1:0])};
    assign part_sum = {2'b00, hi_reg} + addend;

    // Once squaring is done the finished sum sits in hi/lo and is shifted
    // out two bits at a time, most significant pair first.
    assign sum_w   = {hi_reg[15:0], lo_reg};
    assign rem_try = {rem_reg, sum_w[31:30]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign take    = (rem_try >= trial);
    assign diff    = rem_try - trial;

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        mul_x_next = mul_x_reg;
        mul_y_next = mul_y_reg;
        mul_z_next = mul_z_reg;
        dig_x_next = dig_x_reg;
        dig_y_next = dig_y_reg;
        dig_z_next = dig_z_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        unique case (phase_reg)
            PH_IDLE: begin
                if (start) begin
                    phase_next = PH_SQR;
                    cnt_next   = 4'd0;
                    mul_x_next = abs16(axis_x);
                    mul_y_next = abs16(axis_y);
                    mul_z_next = abs16(axis_z);
                    dig_x_next = abs16(axis_x);
                    dig_y_next = abs16(axis_y);
                    dig_z_next = abs16(axis_z);
                    hi_next    = '0;
                    lo_next    = '0;
                    rem_next   = '0;
                    root_next  = '0;
                end
            end
            PH_SQR: begin
                hi_next    = part_sum[18:2];
                lo_next    = {part_sum[1:0], lo_reg[15:2]};
                dig_x_next = {2'b00, dig_x_reg[15:2]};
                dig_y_next = {2'b00, dig_y_reg[15:2]};
                dig_z_next = {2'b00, dig_z_reg[15:2]};
                if (cnt_reg[2:0] == SQR_LAST) begin
                    phase_next = PH_ROOT;
                    cnt_next   = 4'd0;
                end else begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            PH_ROOT: begin
                hi_next   = {1'b0, sum_w[29:14]};
                lo_next   = {sum_w[13:0], 2'b00};
                rem_next  = take ? diff[16:0] : rem_try[16:0];
                root_next = {root_reg[14:0], take};
                if (cnt_reg == ROOT_LAST) begin
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end else begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        mul_x_reg <= mul_x_next;
        mul_y_reg <= mul_y_next;
        mul_z_reg <= mul_z_next;
        dig_x_reg <= dig_x_next;
        dig_y_reg <= dig_y_next;
        dig_z_reg <= dig_z_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
    end

    assign stat.busy = (phase_reg != PH_IDLE);
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

`default_nettype wire
